// ===== design/kis_pkg.sv =====
package kis_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int IDX_W = 20;
	localparam int KEY_W = 32;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [KEY_W-1:0] key;
		logic                    last;
		logic                    ovf;
	} beat_t;

	function automatic logic key_less(input logic signed [KEY_W-1:0] a,
		input logic signed [KEY_W-1:0] b);
		return a < b;
	endfunction

endpackage

// ===== design/key_index_sorter.sv =====
// channel | handshake          | payload
// in      | in_valid, in_stall | point_index, key_value, batch_end
// out     | out_valid, out_stall | sorted_index, sorted_key, final_item, overflow
//
// Load: one beat per cycle, written straight into memory; beats past MAX_ITEMS set overflow.
// Sort: in-place insertion sort over the memory, one compare-and-move per cycle;
//   each item is read and held, then larger keys shift up one place per compare.
// Drain: one read per cycle, while the two-deep output queue has room, via the
//   read register; in_stall stays high from batch end until the drain is done.
// Reset clears fill count, overflow flag and control; the memory is not cleared.
module key_index_sorter #(
	parameter int MAX_ITEMS = kis_pkg::MAX_ITEMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kis_pkg::IDX_W-1:0]       point_index,
	input  logic signed [kis_pkg::KEY_W-1:0] key_value,
	input  logic                            batch_end,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [kis_pkg::IDX_W-1:0]       sorted_index,
	output logic signed [kis_pkg::KEY_W-1:0] sorted_key,
	output logic                            final_item,
	output logic                            overflow
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RDI  = 3'd1;
	localparam logic [2:0] ST_HOLD = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]      state_q, state_n;
	logic [CW-1:0]   fill_q, fill_n;
	logic            ovf_q, ovf_n;
	logic [CW-1:0]   i_q, i_n;
	logic [CW-1:0]   j_q, j_n;
	logic [CW-1:0]   rcnt_q, rcnt_n;
	logic            pend_q, pend_last_q;
	logic            pend_n, pend_last_n;
	kis_pkg::entry_t hold_q;
	logic            hold_ld;

	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	kis_pkg::entry_t wdata, rdata;

	logic            acc, room_ok;
	logic [CW-1:0]   i_inc;
	logic [1:0]      occ;
	logic [2:0]      in_use;
	kis_pkg::beat_t  push_beat, head;

	kis_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign push_beat = '{idx: rdata.idx, key: rdata.key, last: pend_last_q, ovf: ovf_q};

	kis_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pend_q),
		.push_beat (push_beat),
		.stall     (out_stall),
		.valid     (out_valid),
		.head      (head),
		.occ       (occ)
	);

	assign sorted_index = head.idx;
	assign sorted_key   = head.key;
	assign final_item   = head.last;
	assign overflow     = head.ovf;

	assign in_stall = (state_q != ST_LOAD);
	assign acc      = in_valid && !in_stall;
	assign i_inc    = i_q + CW'(1);

	// queue slots taken after this cycle's pop, counting the read in flight
	assign in_use  = {1'b0, occ} + {2'b00, pend_q} - {2'b00, (out_valid && !out_stall)};
	assign room_ok = (in_use < 3'd2);

	always_comb begin
		state_n     = state_q;
		fill_n      = fill_q;
		ovf_n       = ovf_q;
		i_n         = i_q;
		j_n         = j_q;
		rcnt_n      = rcnt_q;
		pend_n      = 1'b0;
		pend_last_n = 1'b0;
		hold_ld     = 1'b0;
		we          = 1'b0;
		waddr       = fill_q[AW-1:0];
		wdata       = '{idx: point_index, key: key_value};
		re          = 1'b0;
		raddr       = i_q[AW-1:0];

		case (state_q)
			ST_LOAD: begin
				if (acc) begin
					if (fill_q < CW'(MAX_ITEMS)) begin
						we     = 1'b1;
						fill_n = fill_q + CW'(1);
					end else begin
						ovf_n = 1'b1;
					end
					if (batch_end) begin
						rcnt_n = '0;
						i_n    = CW'(1);
						state_n = (fill_n <= CW'(1)) ? ST_OUT : ST_RDI;
					end
				end
			end
			ST_RDI: begin
				re      = 1'b1;
				state_n = ST_HOLD;
			end
			ST_HOLD: begin
				hold_ld = 1'b1;
				j_n     = i_q;
				re      = 1'b1;
				raddr   = AW'(i_q - CW'(1));
				state_n = ST_CMP;
			end
			ST_CMP: begin
				// write at j never meets the read at j-2 or i+1, so no forwarding
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				if (kis_pkg::key_less(hold_q.key, rdata.key)) begin
					wdata = rdata;
					j_n   = j_q - CW'(1);
					if (j_q == CW'(1)) begin
						state_n = ST_PUT;
					end else begin
						re    = 1'b1;
						raddr = AW'(j_q - CW'(2));
					end
				end else begin
					wdata = hold_q;
					i_n   = i_inc;
					if (i_inc == fill_q) begin
						state_n = ST_OUT;
					end else begin
						re      = 1'b1;
						raddr   = i_inc[AW-1:0];
						state_n = ST_HOLD;
					end
				end
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = hold_q;
				i_n   = i_inc;
				if (i_inc == fill_q) begin
					state_n = ST_OUT;
				end else begin
					re      = 1'b1;
					raddr   = i_inc[AW-1:0];
					state_n = ST_HOLD;
				end
			end
			ST_OUT: begin
				if (rcnt_q != fill_q) begin
					if (room_ok) begin
						re          = 1'b1;
						raddr       = rcnt_q[AW-1:0];
						rcnt_n      = rcnt_q + CW'(1);
						pend_n      = 1'b1;
						pend_last_n = ((rcnt_q + CW'(1)) == fill_q);
					end
				end else if (!pend_q && !out_valid) begin
					fill_n  = '0;
					ovf_n   = 1'b0;
					state_n = ST_LOAD;
				end
			end
			default: begin
				state_n = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			rcnt_q      <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			fill_q      <= fill_n;
			ovf_q       <= ovf_n;
			i_q         <= i_n;
			j_q         <= j_n;
			rcnt_q      <= rcnt_n;
			pend_q      <= pend_n;
			pend_last_q <= pend_last_n;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_ld) begin
			hold_q <= rdata;
		end
	end

endmodule

// ===== design/kis_store.sv =====
module kis_store #(
	parameter int DEPTH = kis_pkg::MAX_ITEMS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  kis_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output kis_pkg::entry_t rdata
);

	kis_pkg::entry_t mem [DEPTH];
	kis_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/kis_obuf.sv =====
module kis_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kis_pkg::beat_t push_beat,
	input  logic           stall,
	output logic           valid,
	output kis_pkg::beat_t head,
	output logic [1:0]     occ
);

	logic [1:0]     occ_q;
	kis_pkg::beat_t head_q;
	kis_pkg::beat_t skid_q;
	logic           pop;

	assign pop   = (occ_q != 2'd0) && !stall;
	assign valid = (occ_q != 2'd0);
	assign head  = head_q;
	assign occ   = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   occ_q <= occ_q + 2'd1;
				2'b01:   occ_q <= occ_q - 2'd1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	// two-deep queue: head is the visible beat, skid catches the read in flight
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (occ_q == 2'd2) begin
					head_q <= skid_q;
					skid_q <= push_beat;
				end else begin
					head_q <= push_beat;
				end
			end
			2'b10: begin
				if (occ_q == 2'd0) begin
					head_q <= push_beat;
				end else begin
					skid_q <= push_beat;
				end
			end
			2'b01: begin
				head_q <= skid_q;
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

// ===== design/kis_checker.sv =====
module kis_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [kis_pkg::IDX_W-1:0]        sorted_index,
	input logic signed [kis_pkg::KEY_W-1:0] sorted_key,
	input logic                             final_item,
	input logic                             overflow
);

	logic                             open_q;
	logic signed [kis_pkg::KEY_W-1:0] prev_key_q;
	logic                             prev_ovf_q;

	// open_q: a beat of the current batch went out and was not the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (out_valid && !out_stall) begin
			open_q <= !final_item;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid && !out_stall) begin
			prev_key_q <= sorted_key;
			prev_ovf_q <= overflow;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_index)
			&& $stable(sorted_key) && $stable(final_item))
		else $error("stalled output beat changed");

	a_no_load_while_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while results pending");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_q |-> sorted_key >= prev_key_q)
		else $error("keys out of order");

	a_ovf_const: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_q |-> overflow == prev_ovf_q)
		else $error("overflow flag changed within a batch");

endmodule

bind key_index_sorter kis_checker u_kis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sorted_index (sorted_index),
	.sorted_key   (sorted_key),
	.final_item   (final_item),
	.overflow     (overflow)
);

// ===== sim/key_index_sorter_tb.sv =====
`timescale 1ns / 1ps

module key_index_sorter_tb;

	localparam int MAX_ITEMS   = kis_pkg::MAX_ITEMS_DEF;
	localparam int RAND_ITEMS  = 190;
	localparam int DIR_ROWS    = 20;
	localparam int END_SLACK   = 4 * MAX_ITEMS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic [kis_pkg::IDX_W-1:0] idx;
		logic [kis_pkg::KEY_W-1:0] key;
		logic                      last;
		logic                      typed;
		kis_pkg::beat_t            res;
	} stim_row_t;

	localparam kis_pkg::beat_t NO_RES = '0;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [kis_pkg::IDX_W-1:0]        point_index = '0;
	logic signed [kis_pkg::KEY_W-1:0] key_value = '0;
	logic                             batch_end = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [kis_pkg::IDX_W-1:0]        sorted_index;
	logic signed [kis_pkg::KEY_W-1:0] sorted_key;
	logic                             final_item;
	logic                             overflow;

	key_index_sorter #(
		.MAX_ITEMS(MAX_ITEMS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_index(point_index),
		.key_value(key_value),
		.batch_end(batch_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_index(sorted_index),
		.sorted_key(sorted_key),
		.final_item(final_item),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sorted copy of the batch so far, plus drop flag
	kis_pkg::entry_t held [MAX_ITEMS];
	int              held_cnt = 0;
	bit              held_dropped = 1'b0;
	kis_pkg::beat_t  batch_order [$];
	kis_pkg::beat_t  pending_order [$];

	int err_cnt = 0;
	int cycle_cnt = 0;
	int in_quiet = 0;
	int stall_run = 0;
	int stall_pick;

	stim_row_t dir_table [DIR_ROWS];

	function automatic void absorb_point(input kis_pkg::entry_t e, input logic last);
		int             pos;
		kis_pkg::beat_t b;
		if (held_cnt < MAX_ITEMS) begin
			// insert behind every key <= new key: equal keys stay in arrival order
			pos = held_cnt;
			while (pos > 0 && $signed(e.key) < $signed(held[pos-1].key)) begin
				held[pos] = held[pos-1];
				pos--;
			end
			held[pos] = e;
			held_cnt++;
		end else begin
			held_dropped = 1'b1;
		end
		batch_order.delete();
		if (last) begin
			for (int i = 0; i < held_cnt; i++) begin
				b.idx  = held[i].idx;
				b.key  = held[i].key;
				b.last = (i == held_cnt - 1);
				b.ovf  = held_dropped;
				batch_order.push_back(b);
			end
			held_cnt = 0;
			held_dropped = 1'b0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (in_quiet > 0) begin
			in_quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			in_quiet = $urandom_range(10, 40);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [kis_pkg::IDX_W-1:0] rand_index();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return kis_pkg::IDX_W'($urandom_range(0, 20'hFFFFF));
	endfunction

	function automatic logic [kis_pkg::KEY_W-1:0] rand_key();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return $urandom();
		if (r < 12)
			return 32'h8000_0000;
		if (r < 14)
			return 32'h7FFF_FFFF;
		// small set of values so ties show up often
		if (r < 17)
			return $urandom_range(0, 3) << 16;
		return 32'($urandom_range(0, 6)) - 32'd3;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(input logic [kis_pkg::IDX_W-1:0] idx,
		input logic [kis_pkg::KEY_W-1:0] key,
		input logic last, input logic typed, input kis_pkg::beat_t typed_res);
		int              gap;
		kis_pkg::entry_t e;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			point_index <= kis_pkg::IDX_W'($urandom_range(0, 20'hFFFFF));
			key_value <= $urandom();
			batch_end <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_index <= idx;
		key_value <= key;
		batch_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		e.idx = idx;
		e.key = key;
		absorb_point(e, last);
		if (typed && last)
			pending_order.push_back(typed_res);
		else
			foreach (batch_order[i])
				pending_order.push_back(batch_order[i]);
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what);
		if (err_cnt < MAX_REPORTS)
			$display("cycle %0d: %s", cycle_cnt, what);
		err_cnt++;
	endtask

	// receiver: short stalls, some long ones, and stall-free stretches
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 20) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(0, 2);
			end else if (stall_pick < 26) begin
				out_stall <= 1'b1;
				stall_run = $urandom_range(10, 40);
			end else if (stall_pick < 34) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(20, 60);
			end else begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk) begin
		kis_pkg::beat_t exp_b;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_order.size() == 0) begin
				report_mismatch($sformatf("unexpected beat idx %h key %h",
					sorted_index, sorted_key));
			end else begin
				exp_b = pending_order.pop_front();
				if (sorted_index !== exp_b.idx)
					report_mismatch($sformatf("sorted_index %h, want %h",
						sorted_index, exp_b.idx));
				if (sorted_key !== exp_b.key)
					report_mismatch($sformatf("sorted_key %h, want %h",
						sorted_key, exp_b.key));
				if (final_item !== exp_b.last)
					report_mismatch($sformatf("final_item %b, want %b",
						final_item, exp_b.last));
				if (overflow !== exp_b.ovf)
					report_mismatch($sformatf("overflow %b, want %b",
						overflow, exp_b.ovf));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout, %0d beats still expected", pending_order.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int sent;
		int batch_no;
		int len;
		dir_table = '{
			// one-beat batches, mostly at the field extremes
			'{20'h00000, 32'h0000_0000, 1'b1, 1'b1, '{20'h00000, 32'h0000_0000, 1'b1, 1'b0}},
			'{20'hFFFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, '{20'hFFFFF, 32'h7FFF_FFFF, 1'b1, 1'b0}},
			'{20'h00001, 32'h8000_0000, 1'b1, 1'b1, '{20'h00001, 32'h8000_0000, 1'b1, 1'b0}},
			'{20'h80000, 32'hFFFF_FFFF, 1'b1, 1'b1, '{20'h80000, 32'hFFFF_FFFF, 1'b1, 1'b0}},
			// mixed signs with two pairs of equal keys
			'{20'h0000A, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
			'{20'h0000B, 32'hFFFF_0000, 1'b0, 1'b0, NO_RES},
			'{20'h0000C, 32'h0001_0000, 1'b0, 1'b0, NO_RES},
			'{20'h0000D, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
			'{20'h0000E, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
			'{20'h0000F, 32'hFFFF_0000, 1'b0, 1'b0, NO_RES},
			'{20'h00010, 32'h0000_0000, 1'b1, 1'b0, NO_RES},
			// descending arrival, every beat moves all the way down
			'{20'h55555, 32'h0005_0000, 1'b0, 1'b0, NO_RES},
			'{20'hAAAAA, 32'h0004_0000, 1'b0, 1'b0, NO_RES},
			'{20'h12345, 32'h0003_0000, 1'b0, 1'b0, NO_RES},
			'{20'hEDCBA, 32'h0002_0000, 1'b0, 1'b0, NO_RES},
			'{20'h00000, 32'h0001_0000, 1'b1, 1'b0, NO_RES},
			// all keys equal: output must keep arrival order
			'{20'h00003, 32'h1234_5678, 1'b0, 1'b0, NO_RES},
			'{20'h00002, 32'h1234_5678, 1'b0, 1'b0, NO_RES},
			'{20'h00001, 32'h1234_5678, 1'b0, 1'b0, NO_RES},
			'{20'h00000, 32'h1234_5678, 1'b1, 1'b0, NO_RES}
		};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_table[i])
			send_beat(dir_table[i].idx, dir_table[i].key, dir_table[i].last,
				dir_table[i].typed, dir_table[i].res);

		// mostly short batches; one exactly full, one that overflows on its end beat
		sent = 0;
		batch_no = 0;
		while (sent < RAND_ITEMS) begin
			if (batch_no == 2)
				len = MAX_ITEMS;
			else if (batch_no == 5)
				len = MAX_ITEMS + 1;
			else if ($urandom_range(0, 9) < 7)
				len = $urandom_range(1, 6);
			else
				len = $urandom_range(7, 16);
			for (int k = 0; k < len; k++)
				send_beat(rand_index(), rand_key(), k == len - 1, 1'b0, NO_RES);
			sent += len;
			batch_no++;
		end
		in_valid <= 1'b0;

		while (pending_order.size() != 0)
			@(posedge clk);
		repeat (END_SLACK) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
design/kis_pkg.sv
design/kis_store.sv
design/kis_obuf.sv
design/key_index_sorter.sv
design/kis_checker.sv
sim/key_index_sorter_tb.sv
